FILE: rtl/lossless_pixel_predictor_residual_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pixel predictor residual core
// Concurrent checks in simulation, empty bodies in synthesis.
// ---------------------------------------------------------------------------
`ifndef LOSSLESS_PIXEL_PREDICTOR_RESIDUAL_CORE_DEFINES_SVH
`define LOSSLESS_PIXEL_PREDICTOR_RESIDUAL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LPP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpp assertion failed");
// Next-cycle implication
`define LPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpp assertion failed");
`else
`define LPP_ASSERT_NOW(label, clk, rst, ante, cons)
`define LPP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/lpp_pkg.sv
// ---------------------------------------------------------------------------
// lpp_pkg
// Types, register indexes, predictor codes and helpers of the predictor core.
// ---------------------------------------------------------------------------
package lpp_pkg;

   localparam int unsigned DEFAULT_MAX_WIDTH = 4096;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREDICTOR_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd2;

   localparam logic [2:0]  MODE_RESET   = 3'd0;
   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;

   // Predictor codes
   localparam logic [2:0] MODE_LEFT    = 3'd0;
   localparam logic [2:0] MODE_UP      = 3'd1;
   localparam logic [2:0] MODE_UPLEFT  = 3'd2;
   localparam logic [2:0] MODE_PLANE   = 3'd3;
   localparam logic [2:0] MODE_A_HALF  = 3'd4;
   localparam logic [2:0] MODE_B_HALF  = 3'd5;
   localparam logic [2:0] MODE_AVERAGE = 3'd6;
   localparam logic [2:0] MODE_MEDIAN  = 3'd7;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_residual;
      logic [7:0] green_residual;
      logic [7:0] red_residual;
      logic       frame_end;
   } rsp_type;

   // Neighbourhood of one channel handed to a lane
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } lane_in_type;

   // Halve a signed value, truncating toward zero
   function automatic logic signed [10:0] halve(input logic signed [10:0] v);
      logic signed [10:0] t;
      t = v + $signed({10'b0, v[10]});
      return t >>> 1;
   endfunction

endpackage

FILE: rtl/lossless_pixel_predictor_residual_core.sv
// ---------------------------------------------------------------------------
// lossless_pixel_predictor_residual_core
// Stages: the prediction stage register, then the merge output register.
// Throughput: one item per cycle unless output stalls, set by the single line
//   store port that reads the row above and overwrites it in the same cycle.
// Reset clears position counters, neighbours, configuration and valid flags;
//   the line store is not cleared and takes no clearing pass.
// ---------------------------------------------------------------------------
`include "lossless_pixel_predictor_residual_core_defines.svh"

module lossless_pixel_predictor_residual_core import lpp_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned CW   = $clog2(MAX_WIDTH);
   localparam int unsigned CMPW = (CW + 1 > 13) ? CW + 1 : 13;

   // Configuration
   logic [2:0]  mode_ff;
   logic [12:0] width_ff;
   logic [15:0] height_ff;

   // Position and neighbours
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [15:0]   row_ff;
   logic [15:0]   row_in;
   logic [23:0]   left_ff;
   logic [23:0]   left_in;
   logic [23:0]   upleft_ff;
   logic [23:0]   upleft_in;

   // Prediction stage
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_pix_ff;
   logic    s1_first_ff;
   logic    s1_row_end_ff;
   logic    s1_frame_end_ff;
   logic    s1_adv;
   logic    merge_ready;

   logic            accept;
   logic [CMPW-1:0] col_plus;
   logic [16:0]     row_plus;
   logic            row_end;
   logic            frame_end;
   logic [23:0]     cur;
   logic [23:0]     store_rd;
   logic [23:0]     up;
   logic [7:0]      res [3];
   lane_in_type     lane_in [3];

   // Write configuration registers; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PREDICTOR_MODE: mode_ff   <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Accept while the prediction stage can move on
   assign s1_adv    = s1_valid_ff && merge_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // Detect end of row and end of frame; width clamps to the store depth
   assign col_plus  = CMPW'(col_ff) + CMPW'(1);
   assign row_plus  = {1'b0, row_ff} + 17'd1;
   assign row_end   = (width_ff == 13'd0) || (col_plus >= CMPW'(width_ff)) ||
                      (col_plus >= CMPW'(MAX_WIDTH));
   assign frame_end = row_end && ((height_ff == 16'd0) ||
                                  (row_plus >= {1'b0, height_ff}));

   assign col_in = row_end ? '0 : col_plus[CW-1:0];
   assign row_in = frame_end ? 16'd0 : (row_end ? row_plus[15:0] : row_ff);

   // Advance position on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= 16'd0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur = {req_payload.red_in, req_payload.green_in, req_payload.blue_in};

   lpp_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (CW)
   ) u_store (
      .clock (clock),
      .en    (accept),
      .addr  (col_ff),
      .wdata (cur),
      .rdata (store_rd)
   );

   // Hold the item in the prediction stage until the merge takes it
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= req_payload;
         s1_first_ff     <= (row_ff == 16'd0);
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
   end

   // Up neighbour reads as zero on the first row
   assign up = s1_first_ff ? 24'd0 : store_rd;

   // Move the left and up-left neighbours along the row
   assign left_in   = s1_row_end_ff ? 24'd0 :
                      {s1_pix_ff.red_in, s1_pix_ff.green_in, s1_pix_ff.blue_in};
   assign upleft_in = s1_row_end_ff ? 24'd0 : up;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= 24'd0;
         upleft_ff <= 24'd0;
      end else if (s1_adv) begin
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
      end
   end

   // One lane per channel: blue, green, red
   assign lane_in[0] = '{x: s1_pix_ff.blue_in,  a: left_ff[7:0],
                         b: up[7:0],   c: upleft_ff[7:0]};
   assign lane_in[1] = '{x: s1_pix_ff.green_in, a: left_ff[15:8],
                         b: up[15:8],  c: upleft_ff[15:8]};
   assign lane_in[2] = '{x: s1_pix_ff.red_in,   a: left_ff[23:16],
                         b: up[23:16], c: upleft_ff[23:16]};

   for (genvar g = 0; g < 3; g++) begin : g_lane
      lpp_lane u_lane (
         .mode     (mode_ff),
         .nbr      (lane_in[g]),
         .residual (res[g])
      );
   end

   lpp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .in_ready    (merge_ready),
      .blue_res    (res[0]),
      .green_res   (res[1]),
      .red_res     (res[2]),
      .frame_end   (s1_frame_end_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Checks
   `LPP_ASSERT_NEXT(a_row_end_wraps_col, clock, reset, accept && row_end, col_ff == '0)
   `LPP_ASSERT_NEXT(a_frame_end_wraps_row, clock, reset, accept && frame_end, row_ff == 16'd0)
   `LPP_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_pix_ff))
   `LPP_ASSERT_NOW(a_frame_end_on_row_end, clock, reset, s1_valid_ff && s1_frame_end_ff, s1_row_end_ff)

endmodule

FILE: rtl/lpp_lane.sv
// ---------------------------------------------------------------------------
// lpp_lane
// Predicts one colour channel and forms its residual modulo 256.
// ---------------------------------------------------------------------------
module lpp_lane import lpp_pkg::*; (
   input  logic [2:0]  mode,
   input  lane_in_type nbr,
   output logic [7:0]  residual
);

   logic signed [10:0] a_s;
   logic signed [10:0] b_s;
   logic signed [10:0] c_s;
   logic signed [10:0] hi_s;
   logic signed [10:0] lo_s;
   logic signed [10:0] pred;
   logic [10:0]        diff;

   // Widen the neighbours
   assign a_s = $signed({3'b0, nbr.a});
   assign b_s = $signed({3'b0, nbr.b});
   assign c_s = $signed({3'b0, nbr.c});

   assign hi_s = (a_s > b_s) ? a_s : b_s;
   assign lo_s = (a_s > b_s) ? b_s : a_s;

   // Select the prediction
   always_comb begin
      case (mode)
         MODE_LEFT:    pred = a_s;
         MODE_UP:      pred = b_s;
         MODE_UPLEFT:  pred = c_s;
         MODE_PLANE:   pred = a_s + b_s - c_s;
         MODE_A_HALF:  pred = a_s + halve(b_s - c_s);
         MODE_B_HALF:  pred = b_s + halve(a_s - c_s);
         MODE_AVERAGE: pred = halve(a_s + b_s);
         default: begin
            // median edge detector
            if (c_s >= hi_s) begin
               pred = lo_s;
            end else if (c_s <= lo_s) begin
               pred = hi_s;
            end else begin
               pred = a_s + b_s - c_s;
            end
         end
      endcase
   end

   // Keep the low byte of the difference
   assign diff     = {3'b0, nbr.x} - $unsigned(pred);
   assign residual = diff[7:0];

endmodule

FILE: rtl/lpp_line_store.sv
// ---------------------------------------------------------------------------
// lpp_line_store
// One-row pixel memory: read-before-write at a single address per item.
// ---------------------------------------------------------------------------
module lpp_line_store import lpp_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int unsigned ADDR_W    = $clog2(MAX_WIDTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [23:0]       wdata,
   output logic [23:0]       rdata
);

   logic [23:0] mem [MAX_WIDTH];
   logic [23:0] rdata_ff;

   // Read the row above, then overwrite it with the current pixel
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff  <= mem[addr];
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/lpp_merge.sv
// ---------------------------------------------------------------------------
// lpp_merge
// Gathers the three lane residuals and the frame flag into the output item.
// ---------------------------------------------------------------------------
module lpp_merge import lpp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] blue_res,
   input  logic [7:0] green_res,
   input  logic [7:0] red_res,
   input  logic       frame_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Take a new item when the output register is empty or being drained
   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff.blue_residual  <= blue_res;
         data_ff.green_residual <= green_res;
         data_ff.red_residual   <= red_res;
         data_ff.frame_end      <= frame_end;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

FILE: tb/sv/lossless_pixel_predictor_residual_core_test.sv
// ---------------------------------------------------------------------------
// Testbench for the lossless pixel predictor residual core
// Streams RGB pixels through the core and checks every residual item
// against a line-store predictor kept in the bench. A short table of
// directed steps covers reset values, clamped sizes and all predictors.
// Random frames follow under three idling profiles, with a stretch of row
// at a width above the store depth and a long output stall.
// ---------------------------------------------------------------------------
module lossless_pixel_predictor_residual_core_test;
   import lpp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_DEPTH       = DEFAULT_MAX_WIDTH;
   localparam int          RANDOM_PER_STAGE = 520;
   localparam int          WIDE_RUN_ITEMS   = 200;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          DRAIN_CYCLES     = 20;
   localparam int          MAX_PRINTED      = 100;
   // Index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

   typedef struct packed {
      step_kind_e             kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      req_type                px;
      logic                   typed;
      rsp_type                typed_rsp;
   } directed_step_t;

   typedef struct packed {
      req_type px;
      logic    typed;
      rsp_type typed_rsp;
   } pixel_item_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state and register copy
   req_type     line_store [LINE_DEPTH];
   req_type     left_px;
   req_type     upleft_px;
   int          pos_col;
   int          pos_row;
   int          hi_written;
   logic [2:0]  cfg_mode;
   logic [12:0] cfg_width;
   logic [15:0] cfg_height;

   // Traffic between stimulus, driver and checker
   pixel_item_t pixel_q [$];
   rsp_type     residual_q [$];
   pixel_item_t cur_item;
   logic        slot_busy = 1'b0;
   int          send_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          rsp_hold_request = 0;
   int          hold_left = 0;

   int          error_count = 0;
   int          pixels_accepted = 0;
   int          results_seen = 0;
   int          frames_seen = 0;
   int          reg_writes = 0;

   directed_step_t directed_steps [28] = '{
      // After reset: left predictor, no neighbours
      '{STEP_PIXEL, '0, '0, '{8'hff, 8'h00, 8'h80}, 1'b1, '{8'hff, 8'h00, 8'h80, 1'b0}},
      // Width zero acts as one, set mid-row
      '{STEP_WRITE, CSR_IMAGE_WIDTH, 16'd0, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h12, 8'h34, 8'h56}, 1'b0, '0},
      // Height zero acts as one: every pixel closes the frame
      '{STEP_WRITE, CSR_IMAGE_HEIGHT, 16'd0, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h00, 8'hff, 8'h7f}, 1'b1, '{8'h00, 8'hff, 8'h7f, 1'b1}},
      '{STEP_WRITE, CSR_UNUSED, 16'hffff, '0, 1'b0, '0},
      // A 4 by 3 frame, switching predictor from pixel to pixel
      '{STEP_WRITE, CSR_IMAGE_WIDTH, 16'd4, '0, 1'b0, '0},
      '{STEP_WRITE, CSR_IMAGE_HEIGHT, 16'd3, '0, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_UP), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'hff, 8'hff, 8'hff}, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0}},
      '{STEP_PIXEL, '0, '0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h80, 8'h01, 8'hfe}, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h7f, 8'hc0, 8'h03}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_PLANE), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h10, 8'hf0, 8'h55}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_A_HALF), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h01, 8'hfe, 8'h80}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_B_HALF), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'hff, 8'h02, 8'h33}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_AVERAGE), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h44, 8'haa, 8'h0f}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_MEDIAN), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'hc8, 8'h05, 8'h60}, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h03, 8'hfd, 8'h90}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_UPLEFT), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'he0, 8'h1e, 8'h81}, 1'b0, '0},
      '{STEP_WRITE, CSR_PREDICTOR_MODE, 16'(MODE_LEFT), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, '{8'h5a, 8'ha5, 8'h00}, 1'b0, '0}
   };

   lossless_pixel_predictor_residual_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   // Zero acts as one, anything above the line store acts as its depth
   function automatic int effective_width(logic [12:0] w);
      if (w == 0) return 1;
      if (w > LINE_DEPTH) return LINE_DEPTH;
      return w;
   endfunction

   function automatic logic [7:0] channel_residual(logic [2:0] mode, logic [7:0] x,
                                                   logic [7:0] a, logic [7:0] b,
                                                   logic [7:0] c);
      int ia, ib, ic, hi, lo, guess, diff;
      ia = a;
      ib = b;
      ic = c;
      hi = (ia > ib) ? ia : ib;
      lo = (ia > ib) ? ib : ia;
      // Integer division truncates toward zero, as the halving requires
      case (mode)
         MODE_LEFT:    guess = ia;
         MODE_UP:      guess = ib;
         MODE_UPLEFT:  guess = ic;
         MODE_PLANE:   guess = ia + ib - ic;
         MODE_A_HALF:  guess = ia + (ib - ic) / 2;
         MODE_B_HALF:  guess = ib + (ia - ic) / 2;
         MODE_AVERAGE: guess = (ia + ib) / 2;
         default: begin
            if (ic >= hi) guess = lo;
            else if (ic <= lo) guess = hi;
            else guess = ia + ib - ic;
         end
      endcase
      diff = int'(x) - guess;
      return diff[7:0];
   endfunction

   // Work out the residual item of one pixel and advance the raster position
   function automatic rsp_type predict_residuals(req_type px);
      int      col;
      req_type up;
      rsp_type r;
      logic    row_end;
      col = (pos_col > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : pos_col;
      up = (pos_row > 0) ? line_store[col] : '0;
      r.blue_residual  = channel_residual(cfg_mode, px.blue_in, left_px.blue_in,
                                          up.blue_in, upleft_px.blue_in);
      r.green_residual = channel_residual(cfg_mode, px.green_in, left_px.green_in,
                                          up.green_in, upleft_px.green_in);
      r.red_residual   = channel_residual(cfg_mode, px.red_in, left_px.red_in,
                                          up.red_in, upleft_px.red_in);
      line_store[col] = px;
      if (col > hi_written) hi_written = col;
      row_end = (col + 1 >= effective_width(cfg_width));
      r.frame_end = row_end && (pos_row + 1 >= ((cfg_height == 0) ? 1 : int'(cfg_height)));
      if (row_end) begin
         pos_col = 0;
         left_px = '0;
         upleft_px = '0;
         pos_row = r.frame_end ? 0 : ((pos_row + 1) & 16'hffff);
      end else begin
         pos_col = col + 1;
         left_px = px;
         upleft_px = up;
      end
      return r;
   endfunction

   function automatic req_type random_pixel();
      logic [23:0] bits;
      bits = 24'($urandom);
      return bits;
   endfunction

   // Append one pixel item to the send queue
   function automatic void queue_pixel(req_type px, logic typed, rsp_type want);
      pixel_item_t item;
      item.px = px;
      item.typed = typed;
      item.typed_rsp = want;
      pixel_q = {pixel_q, item};
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("[%0t] MISMATCH item %0d: %s", $time, results_seen, msg);
   endtask

   // Hold until every queued pixel has gone in and every residual has come out
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_q.size() != 0 || slot_busy || residual_q.size() != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_PREDICTOR_MODE: cfg_mode = val[2:0];
         CSR_IMAGE_WIDTH:    cfg_width = val[12:0];
         CSR_IMAGE_HEIGHT:   cfg_height = val;
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
      @(negedge clock);
      csr_we = 1'b0;
      @(posedge clock);
   endtask

   // Offer the next pixel, or idle, at the falling edge; hold until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid = 1'b0;
      end else if (!slot_busy) begin
         if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            cur_item = pixel_q.pop_front();
            req_payload = cur_item.px;
            req_valid = 1'b1;
            slot_busy = 1'b1;
         end else begin
            req_valid = 1'b0;
         end
      end
   end

   // Predict each accepted pixel; typed rows keep their own expectation
   always @(posedge clock) begin : accept_side
      rsp_type predicted;
      if (!reset && req_valid && req_ready) begin
         predicted = predict_residuals(cur_item.px);
         residual_q = {residual_q, (cur_item.typed ? cur_item.typed_rsp : predicted)};
         slot_busy = 1'b0;
         pixels_accepted++;
      end
   end

   // Receiver readiness: random idling, or a long hold when one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else begin
         if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // Compare each residual item with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (residual_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_payload));
         end else begin
            want = residual_q.pop_front();
            if (rsp_payload.blue_residual !== want.blue_residual)
               report_mismatch($sformatf("blue residual %h, expected %h",
                                         rsp_payload.blue_residual, want.blue_residual));
            if (rsp_payload.green_residual !== want.green_residual)
               report_mismatch($sformatf("green residual %h, expected %h",
                                         rsp_payload.green_residual, want.green_residual));
            if (rsp_payload.red_residual !== want.red_residual)
               report_mismatch($sformatf("red residual %h, expected %h",
                                         rsp_payload.red_residual, want.red_residual));
            if (rsp_payload.frame_end !== want.frame_end)
               report_mismatch($sformatf("frame end %b, expected %b",
                                         rsp_payload.frame_end, want.frame_end));
         end
         if (rsp_payload.frame_end === 1'b1) frames_seen++;
         results_seen++;
      end
   end

   initial begin : stimulus
      int          step, stage, stage_items, n, wsel, eff;
      logic        first_phase, big_done;
      logic [2:0]  mode_val;
      logic [15:0] w_val, h_val;

      cfg_mode = MODE_RESET;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      left_px = '0;
      upleft_px = '0;
      pos_col = 0;
      pos_row = 0;
      hi_written = -1;
      big_done = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (step = 0; step < $size(directed_steps); step++) begin
         if (directed_steps[step].kind == STEP_WRITE)
            write_register(directed_steps[step].reg_index, directed_steps[step].reg_value);
         else
            queue_pixel(directed_steps[step].px, directed_steps[step].typed,
                        directed_steps[step].typed_rsp);
      end

      // Random frames under three idling profiles
      for (stage = 0; stage < 3; stage++) begin
         stage_items = 0;
         first_phase = 1'b1;
         while (stage_items < RANDOM_PER_STAGE) begin
            mode_val = 3'($urandom_range(0, 7));
            write_register(CSR_PREDICTOR_MODE, 16'(mode_val));
            if (first_phase) begin
               case (stage)
                  0: begin
                     send_idle_pct = 33;
                     rcv_idle_pct = 83;
                  end
                  1: begin
                     send_idle_pct = 83;
                     rcv_idle_pct = 33;
                  end
                  default: begin
                     send_idle_pct = 0;
                     rcv_idle_pct = 0;
                     rsp_hold_request = LONG_HOLD_CYCLES;
                  end
               endcase
            end

            // New width, kept within the written part of the store below row 0
            if ($urandom_range(0, 99) < 80) begin
               wsel = $urandom_range(0, 99);
               if (wsel < 8) w_val = 16'd0;
               else if (wsel < 15) w_val = 16'($urandom_range(17, 64));
               else w_val = 16'($urandom_range(1, 16));
               eff = effective_width(w_val[12:0]);
               if (pos_row != 0 && eff > hi_written + 1) w_val = 16'(hi_written + 1);
               write_register(CSR_IMAGE_WIDTH, w_val);
            end
            if ($urandom_range(0, 99) < 70) begin
               wsel = $urandom_range(0, 99);
               if (wsel < 10) h_val = 16'd0;
               else if (wsel < 13) h_val = 16'hffff;
               else h_val = 16'($urandom_range(1, 6));
               write_register(CSR_IMAGE_HEIGHT, h_val);
            end

            // Keep the sender busy through the long output hold
            n = (first_phase && stage == 2) ? 100 : $urandom_range(1, 40);
            repeat (n) queue_pixel(random_pixel(), 1'b0, '0);
            stage_items += n;
            first_phase = 1'b0;

            // Close the frame, then run part of row 0 at a width above the store depth
            if (stage == 2 && !big_done && stage_items >= 300) begin
               write_register(CSR_IMAGE_HEIGHT, 16'd1);
               if (pos_col != 0 || pos_row != 0) begin
                  eff = effective_width(cfg_width);
                  n = (eff > pos_col) ? eff - pos_col : 1;
                  repeat (n) queue_pixel(random_pixel(), 1'b0, '0);
               end
               write_register(CSR_IMAGE_WIDTH, 16'h1fff);
               repeat (WIDE_RUN_ITEMS) queue_pixel(random_pixel(), 1'b0, '0);
               big_done = 1'b1;
            end
         end
      end

      // Drain and let any stray result show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (residual_q.size() != 0)
         report_mismatch($sformatf("%0d residual items never arrived", residual_q.size()));

      $display("Run covered %0d pixels, %0d frame ends and %0d register writes,",
               pixels_accepted, frames_seen, reg_writes);
      $display("with all eight predictors, clamped sizes, an oversized width and a long stall.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
